### hw/rtl/utf8_stream_decoder_assert.svh
// Assertion macros for the UTF-8 stream decoder RTL; the back end includes them.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define U8SD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("u8sd: assertion failed");
// Condition must never be true outside reset.
`define U8SD_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("u8sd: forbidden condition");
`else
`define U8SD_ASSERT(name, clk, rst, prop)
`define U8SD_NEVER(name, clk, rst, expr)
`endif

`endif

### hw/rtl/u8sd_pkg.sv
// Types shared by the UTF-8 stream decoder modules.
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

   typedef enum logic [1:0] {
      KIND_SCALAR  = 2'd0,
      KIND_INVALID = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [20:0] code_point;
      logic [31:0] lead_offset;
      logic [31:0] invalid_total;
      logic        message_end;
      logic        run_last;
   } result_type;

   // All results caused by one input byte; second is used only when two is set.
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } bundle_type;

endpackage

`default_nettype wire

### hw/rtl/u8sd_front.sv
// Front end: accepts bytes, runs the UTF-8 sequence state, builds result bundles.
`timescale 1ns / 1ps
`default_nettype none

module u8sd_front
   import u8sd_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   output logic       byte_ready,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data,
   input  logic       queue_full,
   output logic       push,
   output bundle_type push_bundle
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [20:0] MAX_SCALAR = 21'h10FFFF;
   localparam logic [20:0] SURR_LO    = 21'h00D800;
   localparam logic [20:0] SURR_HI    = 21'h00DFFF;
   localparam logic [20:0] MIN_LEN2   = 21'h000080;
   localparam logic [20:0] MIN_LEN3   = 21'h000800;
   localparam logic [20:0] MIN_LEN4   = 21'h010000;
   localparam logic [7:0]  CONT_MASK  = 8'hC0;
   localparam logic [7:0]  CONT_TAG   = 8'h80;

   logic                   strict_ff;
   logic [2:0]             exp_len_ff, exp_len_in;
   logic [1:0]             coll_ff, coll_in;
   logic [20:0]            part_ff, part_in;
   logic [COUNT_WIDTH-1:0] start_ff, start_in;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0] inv_ff, inv_in;
   logic                   err_ff, err_in;

   logic       accept;
   logic       used;
   logic       is_cont;
   logic [2:0] coll_sum;
   logic [1:0] n_res;
   result_type res_a, res_b, res_new;

   function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [31:0] low32(input logic [COUNT_WIDTH-1:0] v);
      logic [COUNT_WIDTH+31:0] ext;
      ext = {32'd0, v};
      return ext[31:0];
   endfunction

   function automatic logic good_scalar(input logic [20:0] v, input logic [2:0] len);
      logic [20:0] min_v;
      min_v = (len == 3'd2) ? MIN_LEN2 : ((len == 3'd3) ? MIN_LEN3 : MIN_LEN4);
      return (v >= min_v) && (v <= MAX_SCALAR) && !((v >= SURR_LO) && (v <= SURR_HI));
   endfunction

   function automatic result_type mk(input kind_type k, input logic [20:0] cp,
                                     input logic [31:0] off, input logic [31:0] inv,
                                     input logic fin);
      result_type r;
      r.kind          = k;
      r.code_point    = cp;
      r.lead_offset   = off;
      r.invalid_total = inv;
      r.message_end   = fin;
      r.run_last      = 1'b0;
      return r;
   endfunction

   assign byte_ready = !queue_full;
   assign csr_ready  = 1'b1;
   assign accept     = byte_valid && byte_ready;
   assign is_cont    = (data_byte & CONT_MASK) == CONT_TAG;
   assign coll_sum   = {1'b0, coll_ff} + 3'd1;

   always_comb begin
      exp_len_in = exp_len_ff;
      coll_in    = coll_ff;
      part_in    = part_ff;
      start_in   = start_ff;
      inv_in     = inv_ff;
      err_in     = err_ff;
      used       = 1'b0;
      n_res      = 2'd0;
      res_a      = '0;
      res_b      = '0;
      res_new    = '0;

      if (!err_ff) begin
         // pending sequence: collect or terminate
         if (exp_len_ff != 3'd0) begin
            if (is_cont) begin
               used    = 1'b1;
               part_in = {part_ff[14:0], data_byte[5:0]};
               coll_in = coll_sum[1:0];
               if (coll_sum >= exp_len_ff) begin
                  if (good_scalar(part_in, exp_len_ff)) begin
                     res_new = mk(KIND_SCALAR, part_in, low32(start_ff), low32(inv_in), 1'b0);
                  end else begin
                     inv_in  = bump(inv_in);
                     res_new = mk(strict_ff ? KIND_ERROR : KIND_INVALID, '0, low32(start_ff),
                                  low32(inv_in), strict_ff);
                     if (strict_ff) err_in = 1'b1;
                  end
                  res_a      = res_new;
                  n_res      = 2'd1;
                  exp_len_in = 3'd0;
                  coll_in    = 2'd0;
                  part_in    = '0;
               end
            end else begin
               inv_in     = bump(inv_in);
               res_a      = mk(strict_ff ? KIND_ERROR : KIND_INVALID, '0, low32(start_ff),
                               low32(inv_in), strict_ff);
               n_res      = 2'd1;
               if (strict_ff) err_in = 1'b1;
               exp_len_in = 3'd0;
               coll_in    = 2'd0;
               part_in    = '0;
            end
         end

         // treat the byte as a lead
         if (!used && !err_in) begin
            if (data_byte <= 8'h7F) begin
               res_new = mk(KIND_SCALAR, {13'd0, data_byte}, low32(pos_ff), low32(inv_in), 1'b0);
            end else if (data_byte inside {[8'hC2:8'hDF]}) begin
               exp_len_in = 3'd2;
               part_in    = {16'd0, data_byte[4:0]};
            end else if (data_byte inside {[8'hE0:8'hEF]}) begin
               exp_len_in = 3'd3;
               part_in    = {17'd0, data_byte[3:0]};
            end else if (data_byte inside {[8'hF0:8'hF4]}) begin
               exp_len_in = 3'd4;
               part_in    = {18'd0, data_byte[2:0]};
            end else begin
               inv_in  = bump(inv_in);
               res_new = mk(strict_ff ? KIND_ERROR : KIND_INVALID, '0, low32(pos_ff),
                            low32(inv_in), strict_ff);
               if (strict_ff) err_in = 1'b1;
            end
            if (exp_len_in != 3'd0) begin
               coll_in  = 2'd1;
               start_in = pos_ff;
            end else begin
               if (n_res == 2'd0) res_a = res_new;
               else               res_b = res_new;
               n_res = n_res + 2'd1;
            end
         end

         // flush an unfinished sequence at message end
         if (last_byte && (exp_len_in != 3'd0) && !err_in) begin
            inv_in  = bump(inv_in);
            res_new = mk(strict_ff ? KIND_ERROR : KIND_INVALID, '0, low32(start_in),
                         low32(inv_in), strict_ff);
            if (strict_ff) err_in = 1'b1;
            if (n_res == 2'd0) res_a = res_new;
            else               res_b = res_new;
            n_res      = n_res + 2'd1;
            exp_len_in = 3'd0;
            coll_in    = 2'd0;
            part_in    = '0;
         end
      end

      if (n_res == 2'd1) begin
         res_a.run_last    = 1'b1;
         res_a.message_end = res_a.message_end | last_byte;
      end else if (n_res == 2'd2) begin
         res_b.run_last    = 1'b1;
         res_b.message_end = res_b.message_end | last_byte;
      end

      if (last_byte) begin
         exp_len_in = 3'd0;
         coll_in    = 2'd0;
         part_in    = '0;
         start_in   = '0;
         pos_in     = '0;
         inv_in     = '0;
         err_in     = 1'b0;
      end else begin
         pos_in = bump(pos_ff);
      end
   end

   assign push               = accept && (n_res != 2'd0);
   assign push_bundle.two    = n_res == 2'd2;
   assign push_bundle.first  = res_a;
   assign push_bundle.second = res_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff  <= 1'b0;
         exp_len_ff <= 3'd0;
         coll_ff    <= 2'd0;
         part_ff    <= '0;
         start_ff   <= '0;
         pos_ff     <= '0;
         inv_ff     <= '0;
         err_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            strict_ff <= csr_data;
         end
         if (accept) begin
            exp_len_ff <= exp_len_in;
            coll_ff    <= coll_in;
            part_ff    <= part_in;
            start_ff   <= start_in;
            pos_ff     <= pos_in;
            inv_ff     <= inv_in;
            err_ff     <= err_in;
         end
      end
   end

endmodule

`default_nettype wire

### hw/rtl/u8sd_queue.sv
// Small FIFO of result bundles between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module u8sd_queue
   import u8sd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       not_empty,
   output bundle_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   bundle_type    entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = count_ff == FULL_CNT;
   assign not_empty = count_ff != '0;
   assign head      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/u8sd_back.sv
// Back end: unpacks bundles into single result beats behind an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_assert.svh"

module u8sd_back
   import u8sd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  bundle_type  head,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,  // code_point, lead_offset, invalid_total, run_last, pad
   output logic [1:0]  rsp_tuser,  // kind
   output logic        rsp_tlast
);

   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   logic       half_ff, half_in;
   logic       take;

   // load a new beat whenever the output register is free or being drained
   assign take  = q_valid && (!out_valid_ff || rsp_tready);
   assign q_pop = take && (!head.two || half_ff);

   always_comb begin
      out_in       = out_ff;
      half_in      = half_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (take) begin
         out_in       = half_ff ? head.second : head.first;
         out_valid_in = 1'b1;
         half_in      = head.two && !half_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         half_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.run_last, out_ff.invalid_total,
                        out_ff.lead_offset, out_ff.code_point};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.message_end;

   `U8SD_ASSERT(a_half_has_pair, clock, reset, half_ff |-> (q_valid && head.two))
   `U8SD_ASSERT(a_half_follows_take, clock, reset, $rose(half_ff) |-> $past(take))
   `U8SD_NEVER(a_pop_empty, clock, reset, q_pop && !q_valid)

endmodule

`default_nettype wire

### hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder top level: front end, bundle queue and back end.
//
// Decodes a UTF-8 message at one byte per clock while the queue is not full. Each byte
// on req_ (tlast marks the final byte of a message) gives zero, one or two result beats
// on rsp_: a scalar value, an invalid-sequence marker, or in strict mode one error beat
// that ends the message. The front end decides everything for a byte in the cycle it is
// accepted and writes its results as one bundle into a QUEUE_DEPTH-entry queue; the back
// end drains one result beat per cycle through an output register while rsp_tready is
// high. A byte with two results holds the output register for both of its beats, and the
// queue absorbs that until it fills, when req_tready drops. strict_mode is written
// through csr_; the user must write it only while the decoder is idle, which the block
// itself does not enforce. Position and error counters are COUNT_WIDTH bits and
// saturate; ports carry their low 32 bits.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder
   import u8sd_pkg::*;
#(
   parameter int COUNT_WIDTH = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // code_point, lead_offset, invalid_total, run_last, pad
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // message_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // strict_mode
);

   logic       push, full, pop, not_empty;
   bundle_type push_bundle, head;

   u8sd_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .data_byte  (req_tdata),
      .last_byte  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (full),
      .push       (push),
      .push_bundle(push_bundle)
   );

   u8sd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_bundle),
      .full     (full),
      .pop      (pop),
      .not_empty(not_empty),
      .head     (head)
   );

   u8sd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (not_empty),
      .head      (head),
      .q_pop     (pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the UTF-8 stream decoder.
`timescale 1ns / 1ps

module tb;
   import u8sd_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int STALL_CYCLES   = 300;
   localparam int BLOCK_BYTES    = 230;

   // Decoder model plus the queue of result beats still owed by the DUT.
   class utf8_scoreboard;
      bit         strict;
      bit [2:0]   need_len;
      bit [2:0]   have_len;
      bit [20:0]  partial;
      bit [31:0]  seq_start;
      bit [31:0]  position;
      bit [31:0]  bad_count;
      bit         halted;
      int         decoded_bytes;
      int         mismatches;
      result_type owed_q[$];

      function void set_mode(bit mode);
         strict = mode;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void drop_pending();
         need_len = 0;
         have_len = 0;
         partial  = 0;
      endfunction

      function bit scalar_ok(bit [20:0] v, bit [2:0] len);
         bit [20:0] floor_v;
         floor_v = (len == 2) ? 21'h80 : (len == 3) ? 21'h800 : 21'h10000;
         if (v < floor_v || v > 21'h10FFFF) return 1'b0;
         return !(v >= 21'h00D800 && v <= 21'h00DFFF);
      endfunction

      function void add(kind_type k, bit [20:0] cp, bit [31:0] off, bit msg_end);
         result_type r;
         r.kind          = k;
         r.code_point    = cp;
         r.lead_offset   = off;
         r.invalid_total = bad_count;
         r.message_end   = msg_end;
         r.run_last      = 1'b0;
         owed_q.insert(owed_q.size(), r);
      endfunction

      function void flag_bad(bit [31:0] off);
         if (bad_count != '1) bad_count++;
         if (strict) begin
            add(KIND_ERROR, 21'd0, off, 1'b1);
            halted = 1'b1;
         end else begin
            add(KIND_INVALID, 21'd0, off, 1'b0);
         end
      endfunction

      function void note_byte(bit [7:0] b, bit is_last);
         int         start_size;
         bit         used;
         bit [2:0]   len;
         bit [20:0]  v;
         result_type tail;
         start_size = owed_q.size();
         if (!halted) begin
            decoded_bytes++;
            used = 1'b0;
            len  = 0;
            v    = 0;
            if (need_len != 0) begin
               if (b[7:6] == 2'b10) begin
                  used    = 1'b1;
                  partial = {partial[14:0], b[5:0]};
                  have_len++;
                  if (have_len >= need_len) begin
                     if (scalar_ok(partial, need_len))
                        add(KIND_SCALAR, partial, seq_start, 1'b0);
                     else
                        flag_bad(seq_start);
                     drop_pending();
                  end
               end else begin
                  // a non-continuation cuts the open sequence short
                  flag_bad(seq_start);
                  drop_pending();
               end
            end
            if (!used && !halted) begin
               if (b <= 8'h7F) begin
                  add(KIND_SCALAR, {13'd0, b}, position, 1'b0);
               end else if (b >= 8'hC2 && b <= 8'hDF) begin
                  len = 2;
                  v   = {16'd0, b[4:0]};
               end else if (b >= 8'hE0 && b <= 8'hEF) begin
                  len = 3;
                  v   = {17'd0, b[3:0]};
               end else if (b >= 8'hF0 && b <= 8'hF4) begin
                  len = 4;
                  v   = {18'd0, b[2:0]};
               end else begin
                  flag_bad(position);
               end
               if (len != 0) begin
                  need_len  = len;
                  have_len  = 1;
                  partial   = v;
                  seq_start = position;
               end
            end
            if (is_last && need_len != 0 && !halted) begin
               flag_bad(seq_start);
               drop_pending();
            end
         end
         if (owed_q.size() > start_size) begin
            tail = owed_q[owed_q.size() - 1];
            tail.run_last = 1'b1;
            if (is_last) tail.message_end = 1'b1;
            owed_q[owed_q.size() - 1] = tail;
         end
         if (is_last) begin
            drop_pending();
            seq_start = 0;
            position  = 0;
            bad_count = 0;
            halted    = 1'b0;
         end else if (position != '1) begin
            position++;
         end
      endfunction

      function void check_beat(result_type got);
         result_type want;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: kind %0d cp %h off %0d inv %0d end %b last %b",
                        got.kind, got.code_point, got.lead_offset, got.invalid_total,
                        got.message_end, got.run_last);
            return;
         end
         want = owed_q.pop_front();
         if (got.kind !== want.kind || got.code_point !== want.code_point ||
             got.lead_offset !== want.lead_offset ||
             got.invalid_total !== want.invalid_total ||
             got.message_end !== want.message_end || got.run_last !== want.run_last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected kind %0d cp %h off %0d inv %0d end %b last %b,",
                         " got kind %0d cp %h off %0d inv %0d end %b last %b"},
                        want.kind, want.code_point, want.lead_offset, want.invalid_total,
                        want.message_end, want.run_last,
                        got.kind, got.code_point, got.lead_offset, got.invalid_total,
                        got.message_end, got.run_last);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   utf8_scoreboard sb = new();
   bit [8:0]       stream_q[$];
   int             send_idle_pct;
   int             recv_idle_pct;
   int             quiet_cycles;
   int             stall_left;
   bit             stall_request;

   // {last, byte}; the final byte opens a message that the strict script finishes
   bit [8:0] lenient_script[$] = '{
      9'h000, 9'h0C2, 9'h080, 9'h0F0, 9'h09F, 9'h098, 9'h080, 9'h0ED, 9'h0A0,
      9'h080, 9'h0C0, 9'h0FF, 9'h080, 9'h0E2, 9'h041, 9'h0F4, 9'h090, 9'h080,
      9'h080, 9'h0E0, 9'h080, 9'h080, 9'h0E2, 9'h182, 9'h041};
   bit [8:0] strict_script[$] = '{9'h0C3, 9'h041, 9'h042, 9'h180, 9'h17F};

   utf8_stream_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_request) begin
         rsp_tready    <= 1'b0;
         stall_request <= 1'b0;
         stall_left    <= STALL_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : monitor
      result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.kind          = kind_type'(rsp_tuser);
            got.code_point    = rsp_tdata[20:0];
            got.lead_offset   = rsp_tdata[52:21];
            got.invalid_total = rsp_tdata[84:53];
            got.run_last      = rsp_tdata[85];
            got.message_end   = rsp_tlast;
            sb.check_beat(got);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** utf8_stream_decoder: FAILED **");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_stream();
      bit [8:0] item;
      while (stream_q.size() != 0) begin
         item = stream_q.pop_front();
         while ($urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= item[7:0];
         req_tlast  <= item[8];
         do @(posedge clock); while (!req_tready);
      end
   endtask

   // Drop valid, drain every owed beat, then let bytes without results settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(bit mode);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_mode(mode);
   endtask

   task automatic push_code(bit [20:0] cp, int len, int keep);
      bit [7:0] seq[4];
      case (len)
         1: seq[0] = {1'b0, cp[6:0]};
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++) stream_q.insert(stream_q.size(), {1'b0, seq[i]});
   endtask

   // Mostly well-formed text; noise_pct percent of segments are broken on purpose or random.
   task automatic make_message(int noise_pct);
      int        segs;
      int        len;
      bit [20:0] cp;
      bit [8:0]  tail;
      segs = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      repeat (segs) begin
         if ($urandom_range(99) >= noise_pct) begin
            len = $urandom_range(1, 4);
            case (len)
               1: cp = 21'($urandom_range(0, 'h7F));
               2: cp = 21'($urandom_range('h80, 'h7FF));
               3: begin
                  cp = 21'($urandom_range('h800, 'hFFFF));
                  // move surrogates up out of the surrogate range, to F800-FFFF
                  if (cp >= 21'hD800 && cp <= 21'hDFFF) cp ^= 21'h2000;
               end
               default: cp = 21'($urandom_range('h10000, 'h10FFFF));
            endcase
            push_code(cp, len, len);
         end else begin
            len = $urandom_range(2, 4);
            case ($urandom_range(5))
               0: stream_q.insert(stream_q.size(), {1'b0, 8'($urandom)});
               1: push_code(21'($urandom), len, $urandom_range(1, len - 1));
               2: push_code(21'($urandom_range(0, (len == 2) ? 'h7F :
                                               (len == 3) ? 'h7FF : 'hFFFF)), len, len);
               3: push_code(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
               4: push_code(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
               default: stream_q.insert(stream_q.size(), {1'b0, $urandom_range(1) ?
                                           8'($urandom_range('h80, 'hBF)) :
                                           8'($urandom_range('hF5, 'hFF))});
            endcase
         end
      end
      tail = stream_q[stream_q.size() - 1];
      tail[8] = 1'b1;
      stream_q[stream_q.size() - 1] = tail;
   endtask

   initial begin
      int goal;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b0);
      stream_q = lenient_script;
      send_stream();
      // switch to strict in the middle of an open message
      wait_idle();
      write_mode(1'b1);
      stream_q = strict_script;
      send_stream();

      for (int regime = 0; regime < 3; regime++) begin
         for (int mode = 0; mode < 2; mode++) begin
            wait_idle();
            write_mode(mode[0]);
            send_idle_pct = (regime == 0) ? 7 : (regime == 1) ? 67 : 0;
            recv_idle_pct = (regime == 0) ? 67 : (regime == 1) ? 7 : 0;
            if (regime == 2 && mode == 0) stall_request <= 1'b1;
            goal = sb.decoded_bytes + BLOCK_BYTES;
            while (sb.decoded_bytes < goal) begin
               make_message(mode ? 8 : 35);
               send_stream();
            end
         end
      end

      wait_idle();
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("** utf8_stream_decoder: PASSED **");
      else
         $display("** utf8_stream_decoder: FAILED **");
      $finish;
   end

endmodule

### utf8_stream_decoder.f
+incdir+hw/rtl
hw/rtl/u8sd_pkg.sv
hw/rtl/u8sd_front.sv
hw/rtl/u8sd_queue.sv
hw/rtl/u8sd_back.sv
hw/rtl/utf8_stream_decoder.sv
sim/tb.sv
